>>> rtl/core/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants of the Base32 decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SYM_W      = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STORE_W    = 7;
  localparam int unsigned HELD_W     = 3;
  localparam int unsigned D5_W       = COUNT_BITS + 3;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] MAX_BYTES_RST = 8'd20;

  localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_TWO   = 8'h32;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] DIGIT_OFS  = 8'd24;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LONG  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic             skip;
    logic             bad;
    logic [SYM_W-1:0] sym;
    logic             last;
  } item_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_string;
    status_e           status;
    logic [BYTE_W-1:0] bytes_decoded;
  } result_t;

endpackage

>>> rtl/core/base32_decoder.sv
// ----------------------------------------------------------------------------
// base32_decoder
// Base32 string decoder: one character beat in, decoded byte and status out.
// ----------------------------------------------------------------------------
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata[7:0] in_char, tlast in_last
// m_axis   | out | tdata[7:0] out_byte, [15:8] bytes_decoded; tuser[0] byte_valid,
//          |     | [2:1] status; tlast end_of_string
// cfg      | in  | cfg_data_i[7:0] max_bytes
//
// Takes one character per cycle while the queue is not full; a result beat
// leaves through the classify queue and then the output register of the back.
// Reset sets max_bytes to 20 and clears the string state; no clearing pass.
// A stalled m_axis fills the two-entry queue, then drops s_axis_tready.
// ----------------------------------------------------------------------------
module base32_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [b32d_pkg::CHAR_W-1:0] s_axis_tdata,   // [7:0] in_char
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [7:0] out_byte, [15:8] bytes_decoded
  output logic [2:0]                  m_axis_tuser,   // [0] byte_valid, [2:1] status
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [b32d_pkg::BYTE_W-1:0] cfg_data_i
);

  logic              q_full;
  logic              q_push;
  b32d_pkg::item_t   q_in;
  logic              q_valid;
  b32d_pkg::item_t   q_out;
  logic              q_pop;
  b32d_pkg::result_t res;

  b32d_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  b32d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out),
    .pop_i   (q_pop)
  );

  b32d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {res.bytes_decoded, res.out_byte};
  assign m_axis_tuser = {res.status, res.byte_valid};
  assign m_axis_tlast = res.end_of_string;

endmodule

>>> rtl/core/b32d_front.sv
// ----------------------------------------------------------------------------
// b32d_front
// Accepts character beats and classifies them as skip, data symbol or invalid.
// ----------------------------------------------------------------------------
module b32d_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [b32d_pkg::CHAR_W-1:0]   s_axis_tdata,  // [7:0] in_char
  input  logic                          s_axis_tlast,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output b32d_pkg::item_t               q_item_o
);

  logic [b32d_pkg::CHAR_W-1:0] c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o      = '0;
    q_item_o.last = s_axis_tlast;
    q_item_o.skip = (c == b32d_pkg::CHAR_PAD) || (c == b32d_pkg::CHAR_SPACE) ||
                    (c inside {[b32d_pkg::CHAR_TAB:b32d_pkg::CHAR_CR]});
    if (c inside {[b32d_pkg::CHAR_UP_A:b32d_pkg::CHAR_UP_Z]}) begin
      q_item_o.sym = b32d_pkg::SYM_W'(c - b32d_pkg::CHAR_UP_A);
    end else if (c inside {[b32d_pkg::CHAR_LO_A:b32d_pkg::CHAR_LO_Z]}) begin
      q_item_o.sym = b32d_pkg::SYM_W'(c - b32d_pkg::CHAR_LO_A);
    end else if (c inside {[b32d_pkg::CHAR_TWO:b32d_pkg::CHAR_SEVEN]}) begin
      q_item_o.sym = b32d_pkg::SYM_W'(c - b32d_pkg::DIGIT_OFS);
    end else begin
      q_item_o.bad = 1'b1;
    end
  end

endmodule

>>> rtl/core/b32d_queue.sv
// ----------------------------------------------------------------------------
// b32d_queue
// Short queue of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module b32d_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b32d_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output b32d_pkg::item_t item_o,
  input  logic            pop_i
);

  b32d_pkg::item_t                   mem_q [b32d_pkg::FIFO_DEPTH];
  logic [b32d_pkg::FIFO_PTR_W-1:0]   wptr_q, wptr_d;
  logic [b32d_pkg::FIFO_PTR_W-1:0]   rptr_q, rptr_d;
  logic [b32d_pkg::FIFO_CNT_W-1:0]   cnt_q, cnt_d;

  function automatic logic [b32d_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [b32d_pkg::FIFO_PTR_W-1:0] p
  );
    if (p == b32d_pkg::FIFO_PTR_W'(b32d_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == b32d_pkg::FIFO_CNT_W'(b32d_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i  ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/b32d_back.sv
// ----------------------------------------------------------------------------
// b32d_back
// Gathers symbol bits into bytes, tracks the string status, drives results.
// ----------------------------------------------------------------------------
module b32d_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [b32d_pkg::BYTE_W-1:0]   cfg_data_i,
  input  logic                          q_valid_i,
  input  b32d_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          res_valid_o,
  output b32d_pkg::result_t             res_o,
  input  logic                          res_ready_i
);

  localparam int unsigned ACC_W = b32d_pkg::STORE_W + b32d_pkg::SYM_W;

  logic [b32d_pkg::BYTE_W-1:0]     max_q;
  logic [b32d_pkg::STORE_W-1:0]    store_q, store_d;
  logic [b32d_pkg::HELD_W-1:0]     held_q, held_d;
  logic [b32d_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [b32d_pkg::D5_W-1:0]       d5_q, d5_d;
  logic [b32d_pkg::BYTE_W-1:0]     total_q, total_d;
  logic                            bad_q, bad_d;
  logic                            out_valid_q, out_valid_d;
  b32d_pkg::result_t               out_q, out_d;

  logic [ACC_W-1:0]                acc;
  logic [b32d_pkg::HELD_W:0]       n;
  logic [b32d_pkg::HELD_W-1:0]     sh;
  logic [b32d_pkg::BYTE_W-1:0]     byte_val;
  logic                            have_byte;
  logic [b32d_pkg::COUNT_BITS-1:0] quot;
  b32d_pkg::status_e               status;

  assign cfg_ready_o = 1'b1;
  assign q_pop_o     = q_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    store_d   = store_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    d5_d      = d5_q;
    total_d   = total_q;
    bad_d     = bad_q;
    have_byte = 1'b0;
    byte_val  = '0;
    acc       = {store_q, q_item_i.sym};
    n         = {1'b0, held_q} + 4'd5;
    sh        = b32d_pkg::HELD_W'(n - 4'd8);

    if (!q_item_i.skip) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + 1'b1;
        d5_d  = d5_q + b32d_pkg::D5_W'(5);
      end
      if (!bad_q && (total_q < max_q)) begin
        if (q_item_i.bad) begin
          bad_d = 1'b1;
        end else if (n[b32d_pkg::HELD_W]) begin
          byte_val  = b32d_pkg::BYTE_W'(acc >> sh);
          store_d   = acc[b32d_pkg::STORE_W-1:0] &
                      ((b32d_pkg::STORE_W'(1) << sh) - 1'b1);
          held_d    = sh;
          have_byte = 1'b1;
          total_d   = total_q + 1'b1;
        end else begin
          store_d = acc[b32d_pkg::STORE_W-1:0];
          held_d  = n[b32d_pkg::HELD_W-1:0];
        end
      end
    end

    quot = d5_d[b32d_pkg::D5_W-1:3];
    if (!q_item_i.last) begin
      status = b32d_pkg::ST_OK;
    end else if (cnt_d == '0) begin
      status = b32d_pkg::ST_EMPTY;
    end else if ((max_q == '0) ||
                 (quot > b32d_pkg::COUNT_BITS'(max_q))) begin
      status = b32d_pkg::ST_LONG;
    end else if (bad_d) begin
      status = b32d_pkg::ST_BAD;
    end else begin
      status = b32d_pkg::ST_OK;
    end

    out_d                = out_q;
    out_d.byte_valid     = have_byte;
    out_d.out_byte       = byte_val;
    out_d.end_of_string  = q_item_i.last;
    out_d.status         = status;
    out_d.bytes_decoded  = total_d;

    if (q_item_i.last) begin
      store_d = '0;
      held_d  = '0;
      cnt_d   = '0;
      d5_d    = '0;
      total_d = '0;
      bad_d   = 1'b0;
    end

    out_valid_d = out_valid_q && !res_ready_i;
    if (q_pop_o && (have_byte || q_item_i.last)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= b32d_pkg::MAX_BYTES_RST;
      store_q     <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      d5_q        <= '0;
      total_q     <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (q_pop_o) begin
        store_q <= store_d;
        held_q  <= held_d;
        cnt_q   <= cnt_d;
        d5_q    <= d5_d;
        total_q <= total_d;
        bad_q   <= bad_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && (have_byte || q_item_i.last)) begin
      out_q <= out_d;
    end
  end

endmodule

>>> rtl/core/b32d_checker.sv
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks of the Base32 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_mid_has_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
    else $error("non-final beat without a byte");

  a_mid_status_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == b32d_pkg::ST_OK)
    else $error("status set on a non-final beat");

  a_no_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("byte field nonzero without a byte");

endmodule

bind base32_decoder b32d_checker u_b32d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Base32 decoder. Character beats go in over
// s_axis; a behavioral decoder predicts every result beat (decoded byte,
// running byte count, end-of-string status) and the m_axis stream is checked
// against it in order. Covers directed alphabet/skip/invalid/empty strings,
// the byte limit at its extremes and random strings under random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS = 500;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // [7:0] out_byte, [15:8] bytes_decoded
  logic [2:0]  m_axis_tuser;   // [0] byte_valid, [2:1] status
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;

  base32_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder shadow state
  logic [7:0]                      limit_bytes;
  logic [6:0]                      buf_bits;
  int                              buf_count;
  logic [b32d_pkg::COUNT_BITS-1:0] char_count;
  logic [7:0]                      emitted;
  logic                            bad_char;

  b32d_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      random_sent = 0;
  bit      gaps_on  = 1'b1;
  bit      stalls_on = 1'b1;
  int      stall_left = 0;

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [5:0] char_symbol(logic [7:0] c);
    if (c >= b32d_pkg::CHAR_UP_A && c <= b32d_pkg::CHAR_UP_Z)
      return {1'b0, 5'(c - b32d_pkg::CHAR_UP_A)};
    if (c >= b32d_pkg::CHAR_LO_A && c <= b32d_pkg::CHAR_LO_Z)
      return {1'b0, 5'(c - b32d_pkg::CHAR_LO_A)};
    if (c >= b32d_pkg::CHAR_TWO && c <= b32d_pkg::CHAR_SEVEN)
      return {1'b0, 5'(c - b32d_pkg::DIGIT_OFS)};
    return 6'h20;
  endfunction

  function automatic void clear_string();
    buf_bits   = '0;
    buf_count  = 0;
    char_count = '0;
    emitted    = '0;
    bad_char   = 1'b0;
  endfunction

  function automatic void decode_char(logic [7:0] c, logic last);
    logic [5:0]        sym;
    int                acc;
    int                n;
    logic              got_byte;
    logic [7:0]        value;
    b32d_pkg::result_t res;
    got_byte = 1'b0;
    value = '0;
    if (!(c == b32d_pkg::CHAR_PAD || c == b32d_pkg::CHAR_SPACE ||
          (c >= b32d_pkg::CHAR_TAB && c <= b32d_pkg::CHAR_CR))) begin
      if (char_count != '1) char_count++;
      if (!bad_char && emitted < limit_bytes) begin
        sym = char_symbol(c);
        if (sym[5]) begin
          bad_char = 1'b1;
        end else begin
          acc = (int'(buf_bits) << 5) | int'(sym[4:0]);
          n = buf_count + 5;
          if (n >= 8) begin
            n -= 8;
            value = 8'((acc >> n) & 255);
            acc &= (1 << n) - 1;
            got_byte = 1'b1;
            emitted++;
          end
          buf_bits = 7'(acc);
          buf_count = n;
        end
      end
    end
    if (!got_byte && !last) return;
    res.byte_valid    = got_byte;
    res.out_byte      = value;
    res.end_of_string = last;
    res.status        = b32d_pkg::ST_OK;
    res.bytes_decoded = emitted;
    if (last) begin
      if (char_count == '0) res.status = b32d_pkg::ST_EMPTY;
      else if (limit_bytes == '0 ||
               (longint'(char_count) * 5) / 8 > longint'(limit_bytes))
        res.status = b32d_pkg::ST_LONG;
      else if (bad_char) res.status = b32d_pkg::ST_BAD;
      clear_string();
    end
    pending_results.push_back(res);
  endfunction

  function automatic void note_failure(string what, b32d_pkg::result_t want,
                                       b32d_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected v=%0b byte=%02h eos=%0b st=%0d n=%0d, ",
                "got v=%0b byte=%02h eos=%0b st=%0d n=%0d"},
               $realtime, what, want.byte_valid, want.out_byte, want.end_of_string,
               want.status, want.bytes_decoded, got.byte_valid, got.out_byte,
               got.end_of_string, got.status, got.bytes_decoded);
  endfunction

  always @(posedge clk_i) begin
    b32d_pkg::result_t got;
    b32d_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.byte_valid    = m_axis_tuser[0];
      got.out_byte      = m_axis_tdata[7:0];
      got.end_of_string = m_axis_tlast;
      got.status        = b32d_pkg::status_e'(m_axis_tuser[2:1]);
      got.bytes_decoded = m_axis_tdata[15:8];
      if (pending_results.size() == 0) begin
        want = '0;
        note_failure("unexpected beat", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_failure("mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left <= idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 25) ? idle_len() : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_char(c, last);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] random_alpha();
    int v;
    v = $urandom_range(0, 31);
    if (v >= 26) return b32d_pkg::CHAR_TWO + 8'(v - 26);
    return ($urandom_range(0, 1) ? b32d_pkg::CHAR_UP_A : b32d_pkg::CHAR_LO_A) + 8'(v);
  endfunction

  function automatic logic [7:0] random_skip();
    int r;
    r = $urandom_range(0, 6);
    if (r == 0) return b32d_pkg::CHAR_PAD;
    if (r == 1) return b32d_pkg::CHAR_SPACE;
    return b32d_pkg::CHAR_TAB + 8'(r - 2);
  endfunction

  task automatic send_alpha_run(input int count);
    for (int i = 0; i < count; i++) send_char(random_alpha(), i == count - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limit_bytes = value;
  endtask

  task automatic test_alphabet_and_status();
    send_string("MZXW6===");
    send_char("7", 1'b0);
    send_char(b32d_pkg::CHAR_TAB, 1'b0);
    send_char("a", 1'b0);
    send_char(b32d_pkg::CHAR_CR, 1'b0);
    send_char("z", 1'b0);
    send_char("2", 1'b1);
    send_char(b32d_pkg::CHAR_PAD, 1'b0);
    send_char(b32d_pkg::CHAR_SPACE, 1'b1);
    send_char(8'h00, 1'b0);
    send_char("A", 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_byte_limit();
    write_limit(8'd1);
    send_string("MZXW6");
    send_string("MA7");
    send_string("MA!");
    write_limit(8'd0);
    send_string("AB");
    send_char(b32d_pkg::CHAR_PAD, 1'b1);
    write_limit(8'd255);
    send_alpha_run(408);
    send_alpha_run(410);
  endtask

  task automatic send_random_string();
    logic [7:0] chars[$];
    int         n_data;
    int         noise_at;
    n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 40);
    noise_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_data) : -1;
    for (int i = 0; i <= n_data; i++) begin
      if (i == noise_at) chars.push_back(8'($urandom_range(0, 255)));
      if (i == n_data) break;
      if ($urandom_range(0, 9) == 0) chars.push_back(random_skip());
      chars.push_back(random_alpha());
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 6)) chars.push_back(b32d_pkg::CHAR_PAD);
    if (chars.size() == 0) chars.push_back(random_skip());
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    random_sent += chars.size();
  endtask

  task automatic test_random_strings();
    logic [7:0] limits[6];
    int         phase_end;
    limits = '{8'd2, 8'd255, 8'd8, 8'($urandom_range(1, 255)), 8'd1,
               8'($urandom_range(1, 255))};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      phase_end = (RANDOM_ITEMS * (p + 1)) / 6;
      while (random_sent < phase_end) send_random_string();
    end
  endtask

  initial begin
    limit_bytes = b32d_pkg::MAX_BYTES_RST;
    clear_string();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_alphabet_and_status();
    test_byte_limit();
    test_random_strings();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
